// ----- sv/tksk_pkg.sv -----
// tksk_pkg: shared types and constants for the topological sort block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tksk_pkg;

   localparam int VTX_W = 5;                   // width of vertex fields on the ports
   localparam int CNT_W = 5;                   // width of the vertex count register
   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 4;             // command queue between front and back
   localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [VTX_W-1:0] src_vertex;
      logic [VTX_W-1:0] dst_vertex;
      logic             end_of_edges;
   } req_item_type;

   typedef struct packed {
      logic [VTX_W-1:0] vertex;
      logic             last;
   } rsp_item_type;

   // classified item handed from front to back, vertex indices zero based
   typedef struct packed {
      logic             edge_ok;
      logic             end_mark;
      logic [VTX_W-1:0] src_idx;
      logic [VTX_W-1:0] dst_idx;
   } cmd_type;

endpackage

// ----- sv/tksk_front.sv -----
// tksk_front: vertex count register, edge range check and item classification
// depends on tksk_pkg; feeds tksk_queue
`timescale 1ns / 1ps

module tksk_front #(
   parameter int MAX_VERTICES = tksk_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tksk_pkg::req_item_type               req_data,
   input  logic                                 csr_wr_en,
   input  logic [tksk_pkg::CNT_W-1:0]           csr_wr_data,
   output logic                                 cmd_valid,
   input  logic                                 cmd_stall,
   output tksk_pkg::cmd_type                    cmd_data,
   output logic [$clog2(MAX_VERTICES+1)-1:0]    active_count
);
   import tksk_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);

   logic [CNT_W-1:0] vcount_ff;
   logic [CNT_W-1:0] vcount_in;
   logic             src_ok;
   logic             dst_ok;
   logic             edge_ok;

   always_comb begin
      vcount_in = csr_wr_en ? csr_wr_data : vcount_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VERTEX_COUNT_RESET;
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   // counts above the storage size saturate
   assign active_count = (32'(vcount_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_ff);

   assign src_ok  = (req_data.src_vertex != '0) &&
                    (32'(req_data.src_vertex) <= 32'(active_count));
   assign dst_ok  = (req_data.dst_vertex != '0) &&
                    (32'(req_data.dst_vertex) <= 32'(active_count));
   assign edge_ok = src_ok && dst_ok;

   // an ignored edge without the end mark is dropped here
   assign cmd_valid = req_valid && (edge_ok || req_data.end_of_edges);
   assign req_stall = cmd_stall;

   always_comb begin
      cmd_data.edge_ok  = edge_ok;
      cmd_data.end_mark = req_data.end_of_edges;
      cmd_data.src_idx  = req_data.src_vertex - VTX_W'(1);
      cmd_data.dst_idx  = req_data.dst_vertex - VTX_W'(1);
   end

endmodule

// ----- sv/tksk_queue.sv -----
// tksk_queue: short command queue between front and back
// depends on tksk_pkg for the command type and depth
`timescale 1ns / 1ps

module tksk_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  tksk_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output tksk_pkg::cmd_type out_data
);
   import tksk_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [PW:0]     fill_ff;
   logic [PW:0]     fill_in;
   logic            push;
   logic            pop;

   assign in_stall  = (fill_ff == (PW+1)'(QUEUE_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- sv/tksk_back.sv -----
// tksk_back: adjacency matrix, in-degree lanes, ready queue and sort sequencer
// depends on tksk_pkg; takes commands from tksk_queue, drives the result register
`timescale 1ns / 1ps

module tksk_back #(
   parameter int MAX_VERTICES = tksk_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   output logic                                 cmd_stall,
   input  tksk_pkg::cmd_type                    cmd_data,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]    active_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tksk_pkg::rsp_item_type               rsp_data
);
   import tksk_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int VW = $clog2(MAX_VERTICES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEGREE,
      ST_INIT,
      ST_FETCH,
      ST_TAKE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [MAX_VERTICES-1:0]   adj_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]   adj_in [MAX_VERTICES];
   logic [CW-1:0]             deg_ff [MAX_VERTICES];
   logic [CW-1:0]             deg_in [MAX_VERTICES];
   logic [CW-1:0]             u_ff, u_in;
   logic [CW-1:0]             v_ff, v_in;
   logic [CW-1:0]             head_ff, head_in;
   logic [CW-1:0]             tail_ff, tail_in;
   logic [VW-1:0]             cur_ff, cur_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [VTX_W-1:0]          pend_vtx_ff, pend_vtx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_item_type              rsp_data_ff, rsp_data_in;

   logic [VW-1:0]             fifo_mem [MAX_VERTICES];
   logic [VW-1:0]             rd_ff;
   logic                      push;
   logic [VW-1:0]             push_idx;
   logic                      rd_en;
   logic                      out_free;
   logic [VW-1:0]             v_idx;
   logic [MAX_VERTICES-1:0]   deg_row;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cmd_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign v_idx     = v_ff[VW-1:0];
   assign deg_row   = adj_ff[u_ff[VW-1:0]];

   always_comb begin
      state_in      = state_ff;
      adj_in        = adj_ff;
      deg_in        = deg_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cur_in        = cur_ff;
      pend_valid_in = pend_valid_ff;
      pend_vtx_in   = pend_vtx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      push          = 1'b0;
      push_idx      = v_idx;
      rd_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd_data.edge_ok) begin
                  adj_in[VW'(cmd_data.src_idx)][VW'(cmd_data.dst_idx)] = 1'b1;
               end
               if (cmd_data.end_mark) begin
                  state_in = ST_DEGREE;
                  u_in     = '0;
                  for (int v = 0; v < MAX_VERTICES; v++) begin
                     deg_in[v] = '0;
                  end
               end
            end
         end
         // one matrix row per cycle added into the per-vertex counters
         ST_DEGREE: begin
            if (u_ff == active_count) begin
               state_in = ST_INIT;
               v_in     = '0;
            end else begin
               for (int v = 0; v < MAX_VERTICES; v++) begin
                  deg_in[v] = deg_ff[v] + CW'(deg_row[v]);
               end
               u_in = u_ff + CW'(1);
            end
         end
         // queue the sources in ascending order
         ST_INIT: begin
            if (v_ff == active_count) begin
               state_in = ST_FETCH;
            end else begin
               if (deg_ff[v_idx] == '0) begin
                  push = 1'b1;
               end
               v_in = v_ff + CW'(1);
            end
         end
         ST_FETCH: begin
            if (head_ff == tail_ff) begin
               state_in = ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               head_in  = head_ff + CW'(1);
               state_in = ST_TAKE;
            end
         end
         // the previous vertex goes out now that we know it is not the last
         ST_TAKE: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.vertex = pend_vtx_ff;
                  rsp_data_in.last   = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_vtx_in   = VTX_W'(rd_ff) + VTX_W'(1);
               cur_in        = rd_ff;
               v_in          = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (v_ff == active_count) begin
               state_in = ST_FETCH;
            end else begin
               if (adj_ff[cur_ff][v_idx] && (deg_ff[v_idx] != '0)) begin
                  deg_in[v_idx] = deg_ff[v_idx] - CW'(1);
                  if (deg_ff[v_idx] == CW'(1)) begin
                     push = 1'b1;
                  end
               end
               v_in = v_ff + CW'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.vertex = pend_valid_ff ? pend_vtx_ff : '0;
               rsp_data_in.last   = 1'b1;
               pend_valid_in      = 1'b0;
               head_in            = '0;
               tail_in            = '0;
               for (int r = 0; r < MAX_VERTICES; r++) begin
                  adj_in[r] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push) begin
         tail_in = tail_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int r = 0; r < MAX_VERTICES; r++) begin
            adj_ff[r] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         adj_ff        <= adj_in;
         deg_ff        <= deg_in;
         u_ff          <= u_in;
         v_ff          <= v_in;
         cur_ff        <= cur_in;
         pend_vtx_ff   <= pend_vtx_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   // ready queue storage, registered read at the head
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[tail_ff[VW-1:0]] <= push_idx;
      end
      if (rd_en) begin
         rd_ff <= fifo_mem[head_ff[VW-1:0]];
      end
   end

`ifndef SYNTHESIS
   a_head_behind_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("ready queue head passed tail");

   a_tail_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (tail_ff <= active_count))
      else $error("more vertices queued than the graph holds");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!pend_valid_ff && head_ff == '0 && tail_ff == '0))
      else $error("sort state left behind after finish");

   a_finish_marks_last: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == ST_FINISH) && state_ff == ST_IDLE) |->
         (rsp_valid_ff && rsp_data_ff.last))
      else $error("sort ended without a last item");
`endif

endmodule

// ----- sv/topological_sort_kahn.sv -----
// topological_sort_kahn: top level of the Kahn topological sort block
// depends on tksk_pkg, tksk_front, tksk_queue, tksk_back
//
//   port group   direction  handshake          payload
//   req_*        in         req_valid/stall    req_item_type: src, dst, end mark
//   rsp_*        out        rsp_valid/stall    rsp_item_type: vertex, last
//   csr_*        in         csr_wr_en          vertex count, 5 bits
//
// one item per cycle unless the 4-deep queue is full; in-range edges go into the matrix
// an end item starts the sort: a row sweep for in-degrees, a pass to queue the sources,
//   then a fetch, a take and a row scan per emitted vertex, and a finish step
// while a sort runs the back takes no items; the front fills the queue, then stalls
// results leave through an output register; a stalled output holds the sequencer
// synchronous reset clears the matrix, the queue pointers and the vertex count (16) at once
`timescale 1ns / 1ps

module topological_sort_kahn #(
   parameter int MAX_VERTICES = tksk_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  tksk_pkg::req_item_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tksk_pkg::rsp_item_type      rsp_data,
   input  logic                        csr_wr_en,
   input  logic [tksk_pkg::CNT_W-1:0]  csr_wr_data
);
   import tksk_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);

   logic          fq_valid;
   logic          fq_stall;
   cmd_type       fq_data;
   logic          qb_valid;
   logic          qb_stall;
   cmd_type       qb_data;
   logic [CW-1:0] active_count;

   tksk_front #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .cmd_valid    (fq_valid),
      .cmd_stall    (fq_stall),
      .cmd_data     (fq_data),
      .active_count (active_count)
   );

   tksk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_stall  (fq_stall),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_stall (qb_stall),
      .out_data  (qb_data)
   );

   tksk_back #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (qb_valid),
      .cmd_stall    (qb_stall),
      .cmd_data     (qb_data),
      .active_count (active_count),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

// ----- test/tb_topological_sort_kahn.sv -----
// tb_topological_sort_kahn: self-checking testbench for the kahn topological sort block
// depends on tksk_pkg and topological_sort_kahn; edge items are driven from a queue,
// results are checked against an in-bench model of the sort order
`timescale 1ns / 1ps

module tb_topological_sort_kahn;
   import tksk_pkg::*;

   localparam int NV = MAX_VERTICES_DEFAULT;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 64;

   typedef struct {
      req_item_type item;
      bit           wait_drain;
   } edge_slot_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_item_type     req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_item_type     rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   edge_slot_type    pending_edges[$];
   rsp_item_type     expected_order[$];
   // bit d of row s: edge from vertex s+1 to vertex d+1
   logic [NV-1:0]    edge_rows[NV] = '{default: '0};
   logic [CNT_W-1:0] vertex_limit = VERTEX_COUNT_RESET;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   bit               req_taken = 1'b0;
   int               quiet_cycles = 0;
   int               mismatches = 0;

   topological_sort_kahn DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int active_vertices();
      return (vertex_limit > NV) ? NV : int'(vertex_limit);
   endfunction

   task automatic queue_edge(input int src, input int dst, input bit end_mark,
                             input bit wait_drain);
      edge_slot_type slot;
      slot.item.src_vertex = VTX_W'(src);
      slot.item.dst_vertex = VTX_W'(dst);
      slot.item.end_of_edges = end_mark;
      slot.wait_drain = wait_drain;
      pending_edges.push_back(slot);
   endtask

   // all items sent, all results in, then let the block finish its cleanup
   task automatic settle();
      @(posedge clock);
      while (pending_edges.size() != 0 || req_valid || expected_order.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(input int value);
      settle();
      @(negedge clock);
      csr_wr_data <= CNT_W'(value);
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      vertex_limit = CNT_W'(value);
   endtask

   // edge sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_edges.size() != 0
             && !(pending_edges[0].wait_drain && expected_order.size() != 0)
             && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_edges[0].item;
            req_valid <= 1'b1;
            void'(pending_edges.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // accepted edges update the matrix copy; an end item predicts the whole order
   always @(posedge clock) begin
      int n, src, dst, head, tail, emitted, cur;
      int indeg[NV];
      int ready[NV];
      int order[NV];
      rsp_item_type want, got;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            n = active_vertices();
            src = req_data.src_vertex;
            dst = req_data.dst_vertex;
            if (src >= 1 && src <= n && dst >= 1 && dst <= n)
               edge_rows[src-1][dst-1] = 1'b1;
            if (req_data.end_of_edges) begin
               head = 0;
               tail = 0;
               emitted = 0;
               for (int v = 0; v < n; v++) begin
                  indeg[v] = 0;
                  for (int u = 0; u < n; u++)
                     if (edge_rows[u][v]) indeg[v]++;
                  if (indeg[v] == 0) begin
                     ready[tail] = v;
                     tail++;
                  end
               end
               while (head < tail && emitted < NV) begin
                  cur = ready[head];
                  head++;
                  order[emitted] = cur + 1;
                  emitted++;
                  for (int v = 0; v < n; v++) begin
                     if (edge_rows[cur][v]) begin
                        edge_rows[cur][v] = 1'b0;
                        if (indeg[v] > 0) indeg[v]--;
                        if (indeg[v] == 0 && tail < NV) begin
                           ready[tail] = v;
                           tail++;
                        end
                     end
                  end
               end
               if (emitted == 0) begin
                  want.vertex = '0;
                  want.last = 1'b1;
                  expected_order.push_back(want);
               end else begin
                  for (int i = 0; i < emitted; i++) begin
                     want.vertex = VTX_W'(order[i]);
                     want.last = (i == emitted - 1);
                     expected_order.push_back(want);
                  end
               end
               for (int s = 0; s < NV; s++) edge_rows[s] = '0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_order.size() == 0) begin
               $error("result with nothing expected: vertex %0d last %0b", got.vertex, got.last);
               mismatches++;
            end else begin
               want = expected_order.pop_front();
               if (got.vertex !== want.vertex) begin
                  $error("vertex: expected %0d, got %0d", want.vertex, got.vertex);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, got.last);
                  mismatches++;
               end
            end
         end
         if (req_taken || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      int n, edges, a, b, phase_items;
      bit acyclic;
      int cfg_plan[8];
      cfg_plan = '{16, 1, 31, 0, 8, 16, 3, 12};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // duplicates, zero and out-of-range endpoints, a self loop, then the sort
      queue_edge(3, 5, 0, 0);
      queue_edge(3, 5, 0, 0);
      queue_edge(0, 4, 0, 0);
      queue_edge(4, 0, 0, 0);
      queue_edge(17, 2, 0, 0);
      queue_edge(31, 31, 0, 0);
      queue_edge(2, 2, 0, 0);
      queue_edge(16, 1, 1, 0);
      // empty graph, held back until the previous order is out
      queue_edge(0, 0, 1, 1);
      // full cycle: nothing can be placed
      write_vertex_count(3);
      queue_edge(1, 2, 0, 0);
      queue_edge(2, 3, 0, 0);
      queue_edge(3, 1, 1, 0);
      write_vertex_count(0);
      queue_edge(1, 1, 1, 0);
      write_vertex_count(1);
      queue_edge(1, 1, 1, 0);
      queue_edge(0, 0, 1, 0);
      // count above the maximum saturates
      write_vertex_count(31);
      queue_edge(16, 16, 0, 0);
      queue_edge(15, 16, 1, 0);
      // shrink the graph while edges to higher vertices are still loaded
      write_vertex_count(16);
      queue_edge(10, 2, 0, 0);
      queue_edge(2, 10, 0, 0);
      queue_edge(1, 3, 0, 0);
      write_vertex_count(4);
      queue_edge(0, 0, 1, 0);

      for (int p = 0; p < 8; p++) begin
         write_vertex_count(cfg_plan[p]);
         case (p / 2)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 55;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 55;
            end
            default: begin
               send_idle_pct = 17;
               stall_pct = 17;
            end
         endcase
         phase_items = 0;
         while (phase_items < 24) begin
            n = active_vertices();
            edges = $urandom_range(0, 10);
            acyclic = ($urandom_range(0, 9) < 7);
            for (int e = 0; e <= edges; e++) begin
               if (n < 2 || $urandom_range(0, 7) == 0) begin
                  a = $urandom_range(0, 31);
                  b = $urandom_range(0, 31);
               end else begin
                  a = $urandom_range(1, n);
                  b = $urandom_range(1, n);
                  if (acyclic) begin
                     // keep src below dst so the graph stays a dag
                     if (a == b) b = (a == n) ? a - 1 : a + 1;
                     if (a > b) begin
                        cur_swap: begin
                           int t;
                           t = a;
                           a = b;
                           b = t;
                        end
                     end
                  end
               end
               queue_edge(a, b, e == edges, e == 0 && $urandom_range(0, 9) == 0);
               phase_items++;
            end
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
